>>> src/ppcr_pkg.sv
// ----------------------------------------------------------------------------
// ppcr_pkg
// Shared constants for the point polar conversion and rotation unit: operation
// codes, gain correction and the arctangent table in fractions of a turn.
// ----------------------------------------------------------------------------
package ppcr_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int ITERATIONS_DEF = 16;

    localparam int OP_BITS = 2;
    localparam logic [OP_BITS-1:0] OP_TO_POLAR = 2'd0;
    localparam logic [OP_BITS-1:0] OP_TO_CART  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_ROTATE   = 2'd2;

    localparam int GUARD     = 4;
    localparam int GAIN_FRAC = 24;
    localparam int GAIN_BITS = 25;
    localparam logic signed [GAIN_BITS-1:0] INV_GAIN = 25'sd10188014;

    localparam int ZW        = 32;
    localparam int TABLE_LEN = 24;

    localparam logic [ZW-1:0] ATAN_TURN [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

endpackage

>>> src/point_polar_conversion_rotate.sv
// ----------------------------------------------------------------------------
// point_polar_conversion_rotate
// Stages in order: pre-rotation, micro-rotations, gain multiply, output.
// Throughput: one beat per cycle unless stalled, one micro-rotation per stage.
// A stall at the output holds the whole pipeline; input ready follows it.
// Reset clears the valid bits of every stage; data registers are not reset.
// ----------------------------------------------------------------------------
// Pipelined CORDIC for 2D points: Cartesian to polar (vectoring), polar to
// Cartesian and point rotation (rotation mode), with gain removed by one
// multiply per coordinate, half-up rounding and saturation.
// ----------------------------------------------------------------------------
module point_polar_conversion_rotate
    import ppcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int ITERATIONS = ITERATIONS_DEF,
    localparam int IN_BITS   = 3 * COORD_BITS + ANGLE_BITS,
    localparam int IN_DW     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 3 * COORD_BITS + 2 + ANGLE_BITS,
    localparam int OUT_DW    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // x, y, angle, length
    input  logic [IN_DW-1:0]    i_s_axis_tdata,
    // operation
    input  logic [OP_BITS-1:0]  i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // out_x, out_y, out_angle, out_length
    output logic [OUT_DW-1:0]   o_m_axis_tdata,
    // zero_length
    output logic [0:0]          o_m_axis_tuser
);

    localparam int IW = COORD_BITS + GUARD + 3;
    localparam int PW = IW + GAIN_BITS;
    localparam int SH = GAIN_FRAC + GUARD;
    localparam int SW = PW - SH;
    localparam int NS = ITERATIONS + 1;

    localparam logic signed [PW-1:0] RND    = PW'(1) <<< (SH - 1);
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-COORD_BITS){1'b1}}, {COORD_BITS{1'b0}}};
    localparam logic [ZW-1:0]        A_RND  = ZW'(1) << (ZW - 1 - ANGLE_BITS);

    logic adv;

    // input field unpacking
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic [ANGLE_BITS-1:0]        in_ang;
    logic [COORD_BITS-1:0]        in_len;
    logic [OP_BITS-1:0]           in_op;

    assign in_x   = i_s_axis_tdata[COORD_BITS-1:0];
    assign in_y   = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_ang = i_s_axis_tdata[2*COORD_BITS+ANGLE_BITS-1:2*COORD_BITS];
    assign in_len = i_s_axis_tdata[3*COORD_BITS+ANGLE_BITS-1:2*COORD_BITS+ANGLE_BITS];
    assign in_op  = i_s_axis_tuser;

    assign adv             = i_m_axis_tready || !o_m_axis_tvalid;
    assign o_s_axis_tready = adv;

    // micro-rotation stages
    logic                 r_vld  [NS];
    logic [OP_BITS-1:0]   r_op   [NS];
    logic                 r_zero [NS];
    logic signed [IW-1:0] r_x    [NS];
    logic signed [IW-1:0] r_y    [NS];
    logic signed [ZW:0]   r_z    [NS];

    // pre-rotation into stage 0
    logic signed [IW-1:0] n_x0;
    logic signed [IW-1:0] n_y0;
    logic signed [ZW:0]   n_z0;
    logic                 n_zero0;
    logic signed [IW-1:0] px;
    logic signed [IW-1:0] py;
    logic [ZW-1:0]        pz;

    always_comb begin
        px      = {{(IW-COORD_BITS-GUARD){in_x[COORD_BITS-1]}}, in_x, {GUARD{1'b0}}};
        py      = {{(IW-COORD_BITS-GUARD){in_y[COORD_BITS-1]}}, in_y, {GUARD{1'b0}}};
        pz      = {in_ang, {(ZW-ANGLE_BITS){1'b0}}};
        n_zero0 = 1'b0;
        n_x0    = px;
        n_y0    = py;
        n_z0    = '0;
        case (in_op)
            OP_TO_POLAR: begin
                n_zero0 = (in_x == '0) && (in_y == '0);
                if (in_x[COORD_BITS-1]) begin
                    n_x0 = -px;
                    n_y0 = -py;
                    n_z0 = {1'b0, 1'b1, {(ZW-1){1'b0}}};
                end
            end
            OP_TO_CART, OP_ROTATE: begin
                if (in_op == OP_TO_CART) begin
                    n_x0 = {{(IW-COORD_BITS-GUARD){1'b0}}, in_len, {GUARD{1'b0}}};
                    n_y0 = '0;
                end
                if (pz[ZW-1] ^ pz[ZW-2]) begin
                    n_x0 = -n_x0;
                    n_y0 = -n_y0;
                    pz   = {~pz[ZW-1], pz[ZW-2:0]};
                end
                n_z0 = {pz[ZW-1], pz};
            end
            default: begin
                n_x0 = '0;
                n_y0 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_s_axis_tvalid;
        end
        if (adv) begin
            r_op[0]   <= in_op;
            r_zero[0] <= n_zero0;
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
        end
    end

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
        logic                 pos;
        logic signed [IW-1:0] dx;
        logic signed [IW-1:0] dy;
        logic signed [ZW:0]   at;

        assign dx  = r_y[k] >>> k;
        assign dy  = r_x[k] >>> k;
        assign at  = {1'b0, ATAN_TURN[k]};
        assign pos = (r_op[k] == OP_TO_POLAR) ? r_y[k][IW-1] : !r_z[k][ZW];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (adv) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (adv) begin
                r_op[k+1]   <= r_op[k];
                r_zero[k+1] <= r_zero[k];
                if (pos) begin
                    r_x[k+1] <= r_x[k] - dx;
                    r_y[k+1] <= r_y[k] + dy;
                    r_z[k+1] <= r_z[k] - at;
                end else begin
                    r_x[k+1] <= r_x[k] + dx;
                    r_y[k+1] <= r_y[k] - dy;
                    r_z[k+1] <= r_z[k] + at;
                end
            end
        end
    end

    // gain correction multiply
    logic                  r_m_vld;
    logic [OP_BITS-1:0]    r_m_op;
    logic                  r_m_zero;
    logic signed [PW-1:0]  r_m_px;
    logic signed [PW-1:0]  r_m_py;
    logic [ANGLE_BITS-1:0] r_m_ang;
    logic [ZW-1:0]         ang_sum;

    assign ang_sum = r_z[ITERATIONS][ZW-1:0] + A_RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (adv) begin
            r_m_vld <= r_vld[ITERATIONS];
        end
        if (adv) begin
            r_m_op   <= r_op[ITERATIONS];
            r_m_zero <= r_zero[ITERATIONS];
            r_m_px   <= PW'(r_x[ITERATIONS]) * PW'(INV_GAIN);
            r_m_py   <= PW'(r_y[ITERATIONS]) * PW'(INV_GAIN);
            r_m_ang  <= ang_sum[ZW-1 -: ANGLE_BITS];
        end
    end

    // rounding, saturation and output register
    logic signed [PW-1:0]  sum_x;
    logic signed [PW-1:0]  sum_y;
    logic signed [SW-1:0]  sx;
    logic signed [SW-1:0]  sy;
    logic signed [COORD_BITS:0]   n_ox;
    logic signed [COORD_BITS:0]   n_oy;
    logic [ANGLE_BITS-1:0] n_oang;
    logic [COORD_BITS-1:0] n_olen;
    logic                  n_ozero;

    logic                  r_o_vld;
    logic [OUT_BITS-1:0]   r_o_data;
    logic                  r_o_zero;

    always_comb begin
        sum_x   = r_m_px + RND;
        sum_y   = r_m_py + RND;
        sx      = sum_x[PW-1:SH];
        sy      = sum_y[PW-1:SH];
        n_ox    = '0;
        n_oy    = '0;
        n_oang  = '0;
        n_olen  = '0;
        n_ozero = 1'b0;
        case (r_m_op)
            OP_TO_POLAR: begin
                if (r_m_zero) begin
                    n_ozero = 1'b1;
                end else begin
                    n_oang = r_m_ang;
                    if (sx[SW-1]) begin
                        n_olen = '0;
                    end else if (sx > SAT_HI) begin
                        n_olen = '1;
                    end else begin
                        n_olen = sx[COORD_BITS-1:0];
                    end
                end
            end
            OP_TO_CART, OP_ROTATE: begin
                if (sx > SAT_HI) begin
                    n_ox = SAT_HI[COORD_BITS:0];
                end else if (sx < SAT_LO) begin
                    n_ox = SAT_LO[COORD_BITS:0];
                end else begin
                    n_ox = sx[COORD_BITS:0];
                end
                if (sy > SAT_HI) begin
                    n_oy = SAT_HI[COORD_BITS:0];
                end else if (sy < SAT_LO) begin
                    n_oy = SAT_LO[COORD_BITS:0];
                end else begin
                    n_oy = sy[COORD_BITS:0];
                end
            end
            default: begin
                n_ozero = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (adv) begin
            r_o_vld <= r_m_vld;
        end
        if (adv) begin
            r_o_data <= {n_olen, n_oang, n_oy, n_ox};
            r_o_zero <= n_ozero;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {{(OUT_DW-OUT_BITS){1'b0}}, r_o_data};
    assign o_m_axis_tuser  = r_o_zero;

endmodule

>>> test/tb_point_polar_conversion_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_polar_conversion_rotate
// Self-checking bench for the pipelined CORDIC point unit. Every input beat is
// predicted in fixed point and queued. Each output beat is compared field by
// field with the oldest prediction. Corner points, angles and lengths come
// first. Random points follow for each operation, under both-sided idling,
// then with no idling.
// ----------------------------------------------------------------------------
module tb_point_polar_conversion_rotate
    import ppcr_pkg::*;
();

    localparam int IN_DW        = 88;
    localparam int OUT_DW       = 96;
    localparam int ROT_STEPS    = 16;
    localparam int GUARD_SHIFT  = 4;
    localparam longint GAIN_Q24 = 10188014;
    localparam longint COORD_OUT_MAX = (64'sd1 <<< 24) - 1;
    localparam longint COORD_OUT_MIN = -(64'sd1 <<< 24);
    localparam longint LENGTH_MAX    = (64'sd1 <<< 24) - 1;
    localparam logic [23:0] LENGTH_TOP = 24'd11863283;
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;

    // arctangent of 2^-i in fractions of a turn, scaled by 2^32
    localparam bit [31:0] ATAN_STEP [ROT_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [15:0]        angle;
        logic [23:0]        length;
    } point_req_t;

    typedef struct packed {
        logic signed [24:0] out_x;
        logic signed [24:0] out_y;
        logic [15:0]        out_angle;
        logic [23:0]        out_length;
        logic               zero_length;
    } point_result_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_DW-1:0]    s_tdata;
    logic [OP_BITS-1:0]  s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_DW-1:0]   m_tdata;
    logic [0:0]          m_tuser;

    point_result_t pending_results[$];
    int failure_count = 0;
    int stall_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    point_polar_conversion_rotate dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint remove_gain(input longint v);
        longint p;
        p = v * GAIN_Q24 + (64'sd1 <<< 27);
        return p >>> 28;
    endfunction

    function automatic logic signed [24:0] clamp_coord(input longint v);
        longint c;
        c = v;
        if (c > COORD_OUT_MAX) c = COORD_OUT_MAX;
        if (c < COORD_OUT_MIN) c = COORD_OUT_MIN;
        return c[24:0];
    endfunction

    // counter-clockwise rotation by a 32-bit fraction of a turn
    function automatic void rotate_point(input longint xi, input longint yi,
                                         input bit [31:0] turn_in,
                                         output logic signed [24:0] ox,
                                         output logic signed [24:0] oy);
        longint px, py, dx, dy, zs;
        bit [31:0] turn;
        px = xi;
        py = yi;
        turn = turn_in;
        if (turn[31] ^ turn[30]) begin
            px = -px;
            py = -py;
            turn = turn - 32'h8000_0000;
        end
        zs = longint'($signed(turn));
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = py >>> i;
            dy = px >>> i;
            if (zs >= 0) begin
                px -= dx;
                py += dy;
                zs -= longint'(ATAN_STEP[i]);
            end else begin
                px += dx;
                py -= dy;
                zs += longint'(ATAN_STEP[i]);
            end
        end
        ox = clamp_coord(remove_gain(px));
        oy = clamp_coord(remove_gain(py));
    endfunction

    function automatic point_result_t predict_point_result(input point_req_t req);
        point_result_t res;
        longint px, py, dx, dy, radius;
        bit [31:0] turn;
        res = '0;
        case (req.op)
            OP_TO_POLAR: begin
                if (req.x == 0 && req.y == 0) begin
                    res.zero_length = 1'b1;
                end else begin
                    px = longint'(req.x) <<< GUARD_SHIFT;
                    py = longint'(req.y) <<< GUARD_SHIFT;
                    turn = '0;
                    if (px < 0) begin
                        px = -px;
                        py = -py;
                        turn = 32'h8000_0000;
                    end
                    for (int i = 0; i < ROT_STEPS; i++) begin
                        dx = py >>> i;
                        dy = px >>> i;
                        if (py < 0) begin
                            px -= dx;
                            py += dy;
                            turn -= ATAN_STEP[i];
                        end else begin
                            px += dx;
                            py -= dy;
                            turn += ATAN_STEP[i];
                        end
                    end
                    turn += 32'h0000_8000;
                    res.out_angle = turn[31:16];
                    radius = remove_gain(px);
                    if (radius < 0) radius = 0;
                    if (radius > LENGTH_MAX) radius = LENGTH_MAX;
                    res.out_length = radius[23:0];
                end
            end
            OP_TO_CART: begin
                rotate_point(longint'(req.length) <<< GUARD_SHIFT, 0,
                             {req.angle, 16'h0000}, res.out_x, res.out_y);
            end
            OP_ROTATE: begin
                rotate_point(longint'(req.x) <<< GUARD_SHIFT,
                             longint'(req.y) <<< GUARD_SHIFT,
                             {req.angle, 16'h0000}, res.out_x, res.out_y);
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic signed [23:0] random_coord();
        logic signed [23:0] c;
        case ($urandom_range(5))
            0, 1, 2: c = 24'($urandom);
            3: c = 24'($urandom_range(1023)) - 24'd512;
            4: begin
                case ($urandom_range(4))
                    0: c = 24'h800000;
                    1: c = 24'h7FFFFF;
                    2: c = 24'hFFFFFF;
                    3: c = 24'h000001;
                    default: c = '0;
                endcase
            end
            default: c = 24'($urandom_range(15)) - 24'd8;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] random_angle();
        if ($urandom_range(3) == 0)
            return 16'(($urandom_range(3) << 14) + $urandom_range(2) - 1);
        return 16'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [23:0] random_length();
        case ($urandom_range(4))
            0: return 24'($urandom_range(63));
            1: return 24'(LENGTH_TOP - $urandom_range(63));
            default: return 24'($urandom_range(LENGTH_TOP));
        endcase
    endfunction

    function automatic point_req_t random_point(input logic [OP_BITS-1:0] op);
        point_req_t req;
        req.op     = op;
        req.x      = random_coord();
        req.y      = random_coord();
        req.angle  = random_angle();
        req.length = random_length();
        if ($urandom_range(49) == 0) begin
            req.x = '0;
            req.y = '0;
        end
        return req;
    endfunction

    function automatic point_req_t make_point(input logic [OP_BITS-1:0] op,
                                              input logic [23:0] x,
                                              input logic [23:0] y,
                                              input logic [15:0] angle,
                                              input logic [23:0] length);
        point_req_t req;
        req.op     = op;
        req.x      = x;
        req.y      = y;
        req.angle  = angle;
        req.length = length;
        return req;
    endfunction

    task automatic send_point(input point_req_t req);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.op;
        s_tdata  <= {req.length, req.angle, req.y, req.x};
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(predict_point_result(req));
    endtask

    task automatic note_failure(input string what);
        failure_count++;
        if (failure_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
            note_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endtask

    // output beat checker
    always @(posedge i_clk) begin : result_check
        point_result_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_failure("output beat with no result pending");
            end else begin
                want = pending_results.pop_front();
                check_field("out_x", want.out_x, $signed(m_tdata[24:0]));
                check_field("out_y", want.out_y, $signed(m_tdata[49:25]));
                check_field("out_angle", want.out_angle, m_tdata[65:50]);
                check_field("out_length", want.out_length, m_tdata[89:66]);
                check_field("tdata padding", 0, m_tdata[95:90]);
                check_field("zero_length", want.zero_length, m_tuser[0]);
            end
        end
    end

    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_polar_corners();
        send_point(make_point(OP_TO_POLAR, 24'h000000, 24'h000000, 16'hFFFF, 24'hFFFFFF));
        send_point(make_point(OP_TO_POLAR, 24'h7FFFFF, 24'h000000, 16'h0000, 24'h000000));
        send_point(make_point(OP_TO_POLAR, 24'h800000, 24'h000000, 16'h0000, 24'h000000));
        send_point(make_point(OP_TO_POLAR, 24'h000000, 24'h7FFFFF, 16'h0000, 24'h000000));
        send_point(make_point(OP_TO_POLAR, 24'h000000, 24'h800000, 16'h0000, 24'h000000));
        send_point(make_point(OP_TO_POLAR, 24'h800000, 24'h800000, 16'h0000, 24'h000000));
        send_point(make_point(OP_TO_POLAR, 24'h7FFFFF, 24'h7FFFFF, 16'h0000, 24'h000000));
        send_point(make_point(OP_TO_POLAR, 24'hFFFFFF, 24'h000000, 16'h0000, 24'h000000));
        send_point(make_point(OP_TO_POLAR, 24'h000001, 24'hFFFFFF, 16'h0000, 24'h000000));
        send_point(make_point(OP_TO_POLAR, 24'h000000, 24'hFFFFFF, 16'h0000, 24'h000000));
    endtask

    task automatic test_cartesian_corners();
        send_point(make_point(OP_TO_CART, 24'h000000, 24'h000000, 16'h0000, LENGTH_TOP));
        send_point(make_point(OP_TO_CART, 24'h000000, 24'h000000, 16'hFFFF, LENGTH_TOP));
        send_point(make_point(OP_TO_CART, 24'hFFFFFF, 24'hFFFFFF, 16'h4000, 24'h000000));
        send_point(make_point(OP_TO_CART, 24'h000000, 24'h000000, 16'h8000, 24'h000001));
        send_point(make_point(OP_TO_CART, 24'h000000, 24'h000000, 16'hC000, LENGTH_TOP));
    endtask

    task automatic test_rotate_corners();
        send_point(make_point(OP_ROTATE, 24'h800000, 24'h800000, 16'h0000, 24'h000000));
        send_point(make_point(OP_ROTATE, 24'h7FFFFF, 24'h800000, 16'h8000, 24'h000000));
        send_point(make_point(OP_ROTATE, 24'h800000, 24'h7FFFFF, 16'h3FFF, 24'h000000));
        send_point(make_point(OP_ROTATE, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, LENGTH_TOP));
        send_point(make_point(OP_ROTATE, 24'h000001, 24'h000001, 16'h2000, 24'h000000));
    endtask

    task automatic test_unused_operation();
        send_point(make_point(OP_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, LENGTH_TOP));
        send_point(make_point(OP_UNUSED, 24'h000000, 24'h000000, 16'h0000, 24'h000000));
    endtask

    task automatic test_to_polar_random(input int count);
        repeat (count) send_point(random_point(OP_TO_POLAR));
    endtask

    task automatic test_to_cart_random(input int count);
        repeat (count) send_point(random_point(OP_TO_CART));
    endtask

    task automatic test_rotate_random(input int count);
        repeat (count) send_point(random_point(OP_ROTATE));
    endtask

    task automatic test_mixed_random(input int count);
        repeat (count) send_point(random_point(OP_BITS'($urandom_range(3))));
    endtask

    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        send_idle_pct = 36;
        recv_idle_pct = 68;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_polar_corners();
        test_cartesian_corners();
        test_rotate_corners();
        test_unused_operation();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 68;
                end
                1: begin
                    send_idle_pct = 68;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            test_to_polar_random(120);
            test_to_cart_random(120);
            test_rotate_random(120);
            test_mixed_random(100);
        end

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_failure("results still pending at the end");

        if (failure_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
